[design/acs_pkg.sv]
package acs_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_INTERIOR_PLANES = 2'd0;
	localparam logic [1:0] REG_INV_TWO_DX      = 2'd1;
	localparam logic [1:0] REG_INV_TWO_DY      = 2'd2;
	localparam logic [1:0] REG_CORIOLIS_F      = 2'd3;

	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int PLANE_WIDTH     = 12;
	localparam int RECIP_WIDTH     = 31;
	localparam int FRAC_BITS       = 16;

	// pointer and flags that travel down the pipe with each point
	typedef struct packed {
		logic [PLANE_WIDTH-1:0] plane;
		logic                   produce;
		logic                   last;
	} tag_t;

endpackage

[design/acs_if.sv]
interface acs_in_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] u_value;
	logic signed [DATA_WIDTH-1:0] v_value;
	logic signed [DATA_WIDTH-1:0] theta_value;
	modport source (output valid, u_value, v_value, theta_value, input ready);
	modport sink (input valid, u_value, v_value, theta_value, output ready);
endinterface

interface acs_out_if #(parameter int DATA_WIDTH = 32, parameter int ROW_WIDTH = 6,
	parameter int COL_WIDTH = 4);
	logic                                    valid;
	logic                                    ready;
	logic signed [DATA_WIDTH-1:0]            du_tend;
	logic signed [DATA_WIDTH-1:0]            dv_tend;
	logic signed [DATA_WIDTH-1:0]            dtheta_tend;
	logic [acs_pkg::PLANE_WIDTH-1:0]         plane_index;
	logic [ROW_WIDTH-1:0]                    row_index;
	logic [COL_WIDTH-1:0]                    column_index;
	logic                                    last_result;
	modport source (output valid, du_tend, dv_tend, dtheta_tend, plane_index, row_index,
		column_index, last_result, input ready);
	modport sink (input valid, du_tend, dv_tend, dtheta_tend, plane_index, row_index,
		column_index, last_result, output ready);
endinterface

[design/advection_coriolis_stencil_core.sv]
// Streaming advection / Coriolis stencil, Q16.16.
// Channels: in_ch carries one grid point (u, v, theta) per transfer in plane,
// row, column order: halo plane, interior planes, far halo. out_ch carries one
// tendency result per point of plane 2 onward, for the point a plane behind.
// Configuration: cfg_we / cfg_index / cfg_data, written while idle.
// Throughput: one point per cycle while out_ch does not stall. Results are
// registered through the plane store reads, a difference stage, the
// reciprocal multiply, the velocity multiply, the sum and the saturation.
// Each field keeps two planes in a pair of 2*ROWS*COLUMNS memories written
// together: one is read at the old plane point (and the center for u, v),
// the other at the rows above and below, so no memory sees more than two
// read addresses a cycle. Stores are undefined after reset; reset clears the
// counters, configuration registers and pipeline valid bits only, no clearing pass.
// A stall on out_ch freezes the whole pipe; in_ch.ready then drops, nothing
// is lost or repeated. A point of plane 0 or 1 moves through the pipe
// as a bubble and gives no result.
module advection_coriolis_stencil_core #(
	parameter int ROWS = 64,
	parameter int COLUMNS = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	acs_in_if.sink   in_ch,
	acs_out_if.source out_ch,
	input  logic                                cfg_we,
	input  logic [acs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [acs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int PTS = ROWS * COLUMNS;
	localparam int AW = $clog2(2 * PTS);
	localparam int DW = DATA_WIDTH;
	localparam int PW = acs_pkg::PLANE_WIDTH;
	localparam int FB = acs_pkg::FRAC_BITS;
	localparam int DFW = DW + 1;
	localparam int MW = DFW + acs_pkg::RECIP_WIDTH + 1;
	localparam int PRW = 2 * DW;
	localparam int SW = PRW - FB + 3;
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (DW - 1)) - 1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	// configuration registers
	logic [PW-1:0] planes_q;
	logic [acs_pkg::RECIP_WIDTH-1:0] idx_q, idy_q;
	logic signed [DW-1:0] f_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= PW'(1);
			idx_q <= 31'd65536;
			idy_q <= 31'd65536;
			f_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				acs_pkg::REG_INTERIOR_PLANES: planes_q <= cfg_data[PW-1:0];
				acs_pkg::REG_INV_TWO_DX: idx_q <= cfg_data[30:0];
				acs_pkg::REG_INV_TWO_DY: idy_q <= cfg_data[30:0];
				acs_pkg::REG_CORIOLIS_F: f_q <= DW'($signed(cfg_data));
				default: ;
			endcase
		end
	end

	// pipeline advance: whole pipe moves unless the output register is held
	logic adv;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;
	logic take;
	assign take = in_ch.valid && adv;

	// grid counters
	logic [PW:0] p_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [PW:0] lim;
	assign lim = {1'b0, planes_q} + (PW+1)'(1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			r_q <= '0;
			c_q <= '0;
		end else if (take) begin
			if (32'(c_q) == COLUMNS - 1) begin
				c_q <= '0;
				if (32'(r_q) == ROWS - 1) begin
					r_q <= '0;
					p_q <= (p_q >= lim) ? '0 : p_q + (PW+1)'(1);
				end else begin
					r_q <= r_q + RW'(1);
				end
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	// store addresses
	logic [RW-1:0] rp, rm;
	logic [AW-1:0] here, a_old, a_ctr, a_up, a_dn;
	assign rp = (32'(r_q) == ROWS - 1) ? '0 : r_q + RW'(1);
	assign rm = (r_q == '0) ? RW'(ROWS - 1) : r_q - RW'(1);
	assign here = AW'(32'(r_q) * COLUMNS + 32'(c_q));
	assign a_old = AW'(32'(p_q[0]) * PTS) + here;
	assign a_ctr = AW'(32'(!p_q[0]) * PTS) + here;
	assign a_up = AW'(32'(!p_q[0]) * PTS + 32'(rp) * COLUMNS + 32'(c_q));
	assign a_dn = AW'(32'(!p_q[0]) * PTS + 32'(rm) * COLUMNS + 32'(c_q));

	// plane memories, two copies per field; reads registered into stage 1
	logic [DW-1:0] mem_u [2*PTS];
	logic [DW-1:0] mem_v [2*PTS];
	logic [DW-1:0] mem_t [2*PTS];
	logic [DW-1:0] nbr_u [2*PTS];
	logic [DW-1:0] nbr_v [2*PTS];
	logic [DW-1:0] nbr_t [2*PTS];
	logic signed [DW-1:0] old_s1 [3], up_s1 [3], dn_s1 [3], nx_s1 [3];
	logic signed [DW-1:0] uc_s1, vc_s1;
	acs_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [RW-1:0] row_s1, row_s2, row_s3, row_s4, row_s5;
	logic [CW-1:0] col_s1, col_s2, col_s3, col_s4, col_s5;
	always_ff @(posedge clk) begin
		if (take) begin
			mem_u[a_old] <= in_ch.u_value;
			mem_v[a_old] <= in_ch.v_value;
			mem_t[a_old] <= in_ch.theta_value;
			nbr_u[a_old] <= in_ch.u_value;
			nbr_v[a_old] <= in_ch.v_value;
			nbr_t[a_old] <= in_ch.theta_value;
		end
		if (adv) begin
			old_s1[0] <= mem_u[a_old]; old_s1[1] <= mem_v[a_old]; old_s1[2] <= mem_t[a_old];
			up_s1[0] <= nbr_u[a_up]; up_s1[1] <= nbr_v[a_up]; up_s1[2] <= nbr_t[a_up];
			dn_s1[0] <= nbr_u[a_dn]; dn_s1[1] <= nbr_v[a_dn]; dn_s1[2] <= nbr_t[a_dn];
			uc_s1 <= mem_u[a_ctr];
			vc_s1 <= mem_v[a_ctr];
			nx_s1[0] <= in_ch.u_value; nx_s1[1] <= in_ch.v_value;
			nx_s1[2] <= in_ch.theta_value;
			tag_s1.plane <= PW'(p_q - (PW+1)'(1));
			tag_s1.produce <= (p_q >= (PW+1)'(2)) && (p_q <= lim);
			tag_s1.last <= (p_q - (PW+1)'(1) == {1'b0, planes_q}) &&
				(32'(r_q) == ROWS - 1) && (32'(c_q) == COLUMNS - 1);
			row_s1 <= r_q;
			col_s1 <= c_q;
		end
	end

	// stage 2: exact differences; stage 3: times reciprocal, floor, saturate
	logic signed [DFW-1:0] ddx_s2 [3], ddy_s2 [3];
	logic signed [DW-1:0] uc_s2, vc_s2, uc_s3, vc_s3;
	logic signed [DW-1:0] gx_s3 [3], gy_s3 [3];
	logic signed [MW-1:0] mx [3], my [3];
	logic signed [PRW-1:0] px_s4 [3], py_s4 [3];
	logic signed [PRW-1:0] fv_s4, fu_s4;
	logic signed [SW-1:0] sum_s5 [3];

	function automatic logic signed [DW-1:0] satd(input logic signed [MW-1:0] x);
		logic signed [MW-FB-1:0] t;
		t = x[MW-1:FB];
		if (t > (MW-FB)'(SMAX)) return DW'(SMAX);
		if (t < (MW-FB)'(SMIN)) return DW'(SMIN);
		return t[DW-1:0];
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mx[i] = MW'(ddx_s2[i]) * $signed({1'b0, idx_q});
			my[i] = MW'(ddy_s2[i]) * $signed({1'b0, idy_q});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ddx_s2[i] <= DFW'(nx_s1[i]) - DFW'(old_s1[i]);
				ddy_s2[i] <= DFW'(up_s1[i]) - DFW'(dn_s1[i]);
				gx_s3[i] <= satd(mx[i]);
				gy_s3[i] <= satd(my[i]);
				px_s4[i] <= uc_s3 * gx_s3[i];
				py_s4[i] <= vc_s3 * gy_s3[i];
			end
			fv_s4 <= f_q * vc_s3;
			fu_s4 <= f_q * uc_s3;
			sum_s5[0] <= -(SW'(px_s4[0] >>> FB) + SW'(py_s4[0] >>> FB))
				- SW'(fv_s4 >>> FB);
			sum_s5[1] <= -(SW'(px_s4[1] >>> FB) + SW'(py_s4[1] >>> FB))
				+ SW'(fu_s4 >>> FB);
			sum_s5[2] <= -(SW'(px_s4[2] >>> FB) + SW'(py_s4[2] >>> FB));
			uc_s2 <= uc_s1; vc_s2 <= vc_s1;
			uc_s3 <= uc_s2; vc_s3 <= vc_s2;
			tag_s2 <= tag_s1; tag_s3 <= tag_s2; tag_s4 <= tag_s3; tag_s5 <= tag_s4;
			row_s2 <= row_s1; row_s3 <= row_s2; row_s4 <= row_s3; row_s5 <= row_s4;
			col_s2 <= col_s1; col_s3 <= col_s2; col_s4 <= col_s3; col_s5 <= col_s4;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0; v2_s2 <= 1'b0; v3_s3 <= 1'b0; v4_s4 <= 1'b0; v5_s5 <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			v1_s1 <= in_ch.valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			out_ch.valid <= v5_s5 && tag_s5.produce;
		end
	end

	// output register with final saturation
	function automatic logic signed [DW-1:0] sato(input logic signed [SW-1:0] x);
		if (x > SMAX) return DW'(SMAX);
		if (x < SMIN) return DW'(SMIN);
		return x[DW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.du_tend <= sato(sum_s5[0]);
			out_ch.dv_tend <= sato(sum_s5[1]);
			out_ch.dtheta_tend <= sato(sum_s5[2]);
			out_ch.plane_index <= tag_s5.plane;
			out_ch.row_index <= row_s5;
			out_ch.column_index <= col_s5;
			out_ch.last_result <= tag_s5.last;
		end
	end

	// checks
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready) else $error("ready while stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(c_q) && $stable(r_q)) else $error("counter moved");
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		32'(c_q) < COLUMNS && 32'(r_q) < ROWS) else $error("counter range");
endmodule
